[hw/rtl/gnr_pkg.sv]
// Shared types and constants for the greedy nearest-neighbor route unit.
package gnr_pkg;

  localparam int NODE_W      = 6;
  localparam int COST_W      = 22;
  localparam int STATUS_W    = 2;
  localparam int WEIGHT_IN_W = 16;
  localparam int CFG_W       = 7;

  localparam logic [COST_W-1:0] COST_MAX        = 22'h3FFFFF;
  localparam logic [CFG_W-1:0]  NUM_NODES_RESET = 7'd64;

  // Request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ROUTE = 1'b1;

  // Route status codes
  localparam logic [STATUS_W-1:0] ST_REACHED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_STEP_LIMIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DEAD_END   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SAME_NODE  = 2'd3;

  typedef struct packed {
    logic load_weight;
    logic start_query;
    logic scan_issue;
    logic take_step;
    logic mark_dead;
    logic emit_read;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic trivial;
    logic scan_last;
    logic found;
    logic walk_done;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/gnr_req_if.sv]
// Request channel: weight loads and route queries.
interface gnr_req_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   req_type;
  logic        [gnr_pkg::NODE_W-1:0]      row;
  logic        [gnr_pkg::NODE_W-1:0]      col;
  logic signed [gnr_pkg::WEIGHT_IN_W-1:0] weight;
  logic        [gnr_pkg::NODE_W-1:0]      start_node;
  logic        [gnr_pkg::NODE_W-1:0]      end_node;

  modport source (
    output valid, req_type, row, col, weight, start_node, end_node,
    input  ready
  );
  modport sink (
    input  valid, req_type, row, col, weight, start_node, end_node,
    output ready
  );
endinterface

[hw/rtl/gnr_rsp_if.sv]
// Result channel: one visited node per result.
interface gnr_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [gnr_pkg::NODE_W-1:0]      node;
  logic [gnr_pkg::COST_W-1:0]      total_cost;
  logic [gnr_pkg::STATUS_W-1:0]    status;
  logic                            is_last;

  modport source (
    output valid, node, total_cost, status, is_last,
    input  ready
  );
  modport sink (
    input  valid, node, total_cost, status, is_last,
    output ready
  );
endinterface

[hw/rtl/gnr_datapath.sv]
// Datapath: weight memory, row scan, walk registers, path memory, output register.
module gnr_datapath #(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic        [gnr_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic        [gnr_pkg::NODE_W-1:0]      row_i,
  input  logic        [gnr_pkg::NODE_W-1:0]      col_i,
  input  logic signed [gnr_pkg::WEIGHT_IN_W-1:0] weight_i,
  input  logic        [gnr_pkg::NODE_W-1:0]      start_node_i,
  input  logic        [gnr_pkg::NODE_W-1:0]      end_node_i,
  input  logic                                   rsp_ready_i,
  output logic                                   rsp_valid_o,
  output logic        [gnr_pkg::NODE_W-1:0]      node_o,
  output logic        [gnr_pkg::COST_W-1:0]      total_cost_o,
  output logic        [gnr_pkg::STATUS_W-1:0]    status_o,
  output logic                                   is_last_o,
  input  gnr_pkg::cmd_t                          cmd_i,
  output gnr_pkg::sts_t                          sts_o
);
  import gnr_pkg::*;

  localparam int NW    = $clog2(MAX_NODES);
  localparam int PW    = (NW > NODE_W) ? NW : NODE_W;
  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = ((WEIGHT_BITS > COST_W) ? WEIGHT_BITS : COST_W) + 1;
  localparam logic signed [32:0] W_HI = 33'((64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1);
  localparam logic signed [32:0] W_LO = -W_HI - 33'sd1;

  logic [CFG_W-1:0]       num_nodes_q;
  logic [WEIGHT_BITS-1:0] wmem [DEPTH];
  logic [PW-1:0]          pmem [MAX_NODES];

  logic [WEIGHT_BITS-1:0] rdata_q, best_q;
  logic [NW-1:0]          j_q, rd_idx_q, cur_q, prev_q, best_idx_q;
  logic [NW-1:0]          n_last_q, step_q, k_q, n_last_c;
  logic                   rd_vld_q, found_q, prev_vld_q, rsp_valid_q;
  logic [NODE_W-1:0]      end_q;
  logic [COST_W-1:0]      cost_q, cost_sat;
  logic [STATUS_W-1:0]    status_q;
  logic [PW-1:0]          prd_q;

  logic [NODE_W-1:0]      node_q;
  logic [COST_W-1:0]      out_cost_q;
  logic [STATUS_W-1:0]    out_status_q;
  logic                   out_last_q;

  logic                   out_of_range, load_ok, usable, take_c, hit_end;
  logic signed [32:0]     w_ext, w_sat;
  logic [AW-1:0]          waddr, raddr;
  logic [SW-1:0]          cost_sum;
  logic                   pwe;
  logic [NW-1:0]          pwaddr;
  logic [PW-1:0]          pwdata;

  // Clamp the node count to 1..MAX_NODES; keep the last usable index.
  always_comb begin
    if (num_nodes_q == '0) begin
      n_last_c = '0;
    end else if (32'(num_nodes_q) > MAX_NODES) begin
      n_last_c = NW'(MAX_NODES - 1);
    end else begin
      n_last_c = NW'(32'(num_nodes_q) - 1);
    end
  end

  assign out_of_range = (32'(start_node_i) > 32'(n_last_c)) ||
                        (32'(end_node_i) > 32'(n_last_c));

  // Load: saturate to the stored weight range, drop out-of-range entries.
  assign w_ext   = {{17{weight_i[WEIGHT_IN_W-1]}}, weight_i};
  assign w_sat   = (w_ext > W_HI) ? W_HI : ((w_ext < W_LO) ? W_LO : w_ext);
  assign load_ok = (32'(row_i) < MAX_NODES) && (32'(col_i) < MAX_NODES);
  assign waddr   = AW'(32'(row_i) * MAX_NODES + 32'(col_i));
  assign raddr   = AW'(32'(cur_q) * MAX_NODES + 32'(j_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_weight && load_ok) begin
      wmem[waddr] <= w_sat[WEIGHT_BITS-1:0];
    end
    if (cmd_i.scan_issue) begin
      rdata_q <= wmem[raddr];
    end
  end

  // Candidate check on the word read last cycle.
  assign usable = !rdata_q[WEIGHT_BITS-1] && (|rdata_q) &&
                  !(prev_vld_q && (prev_q == rd_idx_q));
  assign take_c = rd_vld_q && usable && (!found_q || (rdata_q < best_q));

  assign hit_end  = 32'(best_idx_q) == 32'(end_q);
  assign cost_sum = SW'(cost_q) + SW'(best_q);
  assign cost_sat = (cost_sum > SW'(COST_MAX)) ? COST_MAX : cost_sum[COST_W-1:0];

  // Path memory write port.
  always_comb begin
    pwe    = cmd_i.start_query || cmd_i.take_step;
    pwaddr = cmd_i.start_query ? '0 : NW'(step_q + 1'b1);
    pwdata = cmd_i.start_query ? PW'(start_node_i) : PW'(best_idx_q);
  end

  always_ff @(posedge clk_i) begin
    if (pwe) begin
      pmem[pwaddr] <= pwdata;
    end
    if (cmd_i.emit_read) begin
      prd_q <= pmem[k_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_nodes_q <= NUM_NODES_RESET;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      prev_vld_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
      j_q         <= '0;
      n_last_q    <= '0;
      step_q      <= '0;
      k_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        num_nodes_q <= cfg_wdata_i;
      end
      rd_vld_q <= cmd_i.scan_issue;
      if (cmd_i.start_query) begin
        n_last_q   <= n_last_c;
        prev_vld_q <= 1'b0;
        step_q     <= '0;
        j_q        <= '0;
        found_q    <= 1'b0;
        k_q        <= '0;
      end
      if (cmd_i.scan_issue) begin
        j_q <= j_q + 1'b1;
      end
      if (take_c) begin
        found_q <= 1'b1;
      end
      if (cmd_i.take_step) begin
        prev_vld_q <= 1'b1;
        step_q     <= step_q + 1'b1;
        j_q        <= '0;
        found_q    <= 1'b0;
      end
      if (cmd_i.emit_load) begin
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.emit_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_query) begin
      cur_q    <= NW'(start_node_i);
      end_q    <= end_node_i;
      cost_q   <= '0;
      status_q <= out_of_range ? ST_DEAD_END : ST_SAME_NODE;
    end
    if (cmd_i.scan_issue) begin
      rd_idx_q <= j_q;
    end
    if (take_c) begin
      best_q     <= rdata_q;
      best_idx_q <= rd_idx_q;
    end
    if (cmd_i.take_step) begin
      cost_q   <= cost_sat;
      prev_q   <= cur_q;
      cur_q    <= best_idx_q;
      status_q <= hit_end ? ST_REACHED : ST_STEP_LIMIT;
    end
    if (cmd_i.mark_dead) begin
      status_q <= ST_DEAD_END;
    end
    if (cmd_i.emit_load) begin
      node_q       <= prd_q[NODE_W-1:0];
      out_cost_q   <= cost_q;
      out_status_q <= status_q;
      out_last_q   <= sts_o.emit_last;
    end
  end

  always_comb begin
    sts_o.trivial   = out_of_range || (start_node_i == end_node_i);
    sts_o.scan_last = (j_q == n_last_q);
    sts_o.found     = found_q;
    sts_o.walk_done = found_q && ((NW'(step_q + 1'b1) == n_last_q) || hit_end);
    sts_o.emit_last = (k_q == step_q);
    sts_o.out_free  = !rsp_valid_q || rsp_ready_i;
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign node_o       = node_q;
  assign total_cost_o = out_cost_q;
  assign status_o     = out_status_q;
  assign is_last_o    = out_last_q;

  a_emit_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_load |-> (!rsp_valid_q || rsp_ready_i))
    else $error("result loaded over a pending result");

  a_step_needs_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take_step |-> found_q)
    else $error("move taken without a usable edge");

  a_scan_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_issue |-> (j_q <= n_last_q))
    else $error("scan index beyond node count");

endmodule

[hw/rtl/gnr_controller.sv]
// Controller: sequences loads, row scans, moves and result emission.
module gnr_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic          req_is_route_i,
  output logic          req_ready_o,
  output gnr_pkg::cmd_t cmd_o,
  input  gnr_pkg::sts_t sts_i
);
  import gnr_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_DRAIN   = 3'd2;
  localparam logic [2:0] S_STEP    = 3'd3;
  localparam logic [2:0] S_EMIT_RD = 3'd4;
  localparam logic [2:0] S_EMIT_WR = 3'd5;

  logic [2:0] state_q, state_d;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          if (req_is_route_i) begin
            cmd_o.start_query = 1'b1;
            state_d = sts_i.trivial ? S_EMIT_RD : S_SCAN;
          end else begin
            cmd_o.load_weight = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_STEP;
      end
      S_STEP: begin
        if (!sts_i.found) begin
          cmd_o.mark_dead = 1'b1;
          state_d = S_EMIT_RD;
        end else begin
          cmd_o.take_step = 1'b1;
          state_d = sts_i.walk_done ? S_EMIT_RD : S_SCAN;
        end
      end
      S_EMIT_RD: begin
        cmd_o.emit_read = 1'b1;
        state_d = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          state_d = sts_i.emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_dead_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP && !sts_i.found) |=> (state_q == S_EMIT_RD))
    else $error("dead end did not go to emission");

  a_stall_holds_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT_WR && !sts_i.out_free) |=> (state_q == S_EMIT_WR))
    else $error("emission advanced while result slot busy");

endmodule

[hw/rtl/greedy_nearest_neighbour_route_unit.sv]
// Top level of the greedy nearest-neighbor route unit.
//
// Usage:
//   req_i carries one request per handshake. A load request (req_type 0)
//   writes one weight of the adjacency matrix and gives no
//   result. A route request (req_type 1) walks greedily from start_node
//   and then returns one result per visited node on rsp_o, is_last set
//   on the final one; total_cost and status repeat in every result.
//   cfg_we_i / cfg_wdata_i set the node count n, used by the next query.
// Flow: one weight memory read per cycle sets the pace. Each move scans
//   one row, drains the last read and then steps; each result is read
//   from the path memory, then loaded into the output register once it
//   is free. Requests are taken one at a time, only while the unit is
//   idle.
// Reset: control state clears and n returns to 64. The weight and path
//   memories are not cleared; load every weight a query can reach first.
// Stall: the output register holds a result until rsp_o.ready; emission
//   waits, and the last result may wait there while a new request enters.
module greedy_nearest_neighbour_route_unit #(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  gnr_req_if.sink                    req_i,
  gnr_rsp_if.source                  rsp_o,
  input  logic                       cfg_we_i,
  input  logic [gnr_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import gnr_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic req_ready;

  // Sequencer: owns the request handshake and drives the datapath.
  gnr_controller u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_i.valid),
    .req_is_route_i (req_i.req_type == REQ_ROUTE),
    .req_ready_o    (req_ready),
    .cmd_o          (cmd),
    .sts_i          (sts)
  );

  assign req_i.ready = req_ready;

  // Memories, walk state and the result register.
  gnr_datapath #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .row_i        (req_i.row),
    .col_i        (req_i.col),
    .weight_i     (req_i.weight),
    .start_node_i (req_i.start_node),
    .end_node_i   (req_i.end_node),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .node_o       (rsp_o.node),
    .total_cost_o (rsp_o.total_cost),
    .status_o     (rsp_o.status),
    .is_last_o    (rsp_o.is_last),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the greedy nearest-neighbor route unit.
`timescale 1ns / 1ps

module tb_top;
  import gnr_pkg::*;

  localparam int MAX_NODES   = 64;
  localparam int QUIET_LIMIT = 30000;  // longest quiet stretch is the long result hold of test_backpressure

  typedef struct packed {
    logic [NODE_W-1:0]   node;
    logic [COST_W-1:0]   total_cost;
    logic [STATUS_W-1:0] status;
    logic                is_last;
  } route_result_t;

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  gnr_req_if req_if ();
  gnr_rsp_if rsp_if ();

  greedy_nearest_neighbour_route_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Mirror of the unit: adjacency weights, which entries hold a loaded value,
  // and the node-count register.
  logic signed [WEIGHT_IN_W-1:0] weight_mat [MAX_NODES][MAX_NODES];
  bit                            loaded     [MAX_NODES][MAX_NODES];
  logic [CFG_W-1:0]              cfg_nodes = NUM_NODES_RESET;

  // Outcome of the last predicted walk.
  logic [NODE_W-1:0]   route_path [MAX_NODES];
  int                  route_len;
  logic [COST_W-1:0]   route_cost;
  logic [STATUS_W-1:0] route_status;

  route_result_t expected_results[$];

  bit idle_en         = 1'b1;
  int rsp_hold_cycles = 0;
  int error_count     = 0;
  int loads_sent      = 0;
  int routes_sent     = 0;
  int results_seen    = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int quiet_cycles    = 0;

  // Node count the unit actually uses: zero acts as one, anything past the
  // matrix size acts as the matrix size.
  function automatic int active_nodes();
    if (cfg_nodes == 0) return 1;
    if (cfg_nodes > MAX_NODES) return MAX_NODES;
    return int'(cfg_nodes);
  endfunction

  // Walk greedily from src toward dst and leave the visited nodes, cost and
  // status in route_*. Return the first row the walk would scan that still
  // holds unloaded entries, or -1 when every read lands on a loaded weight.
  function automatic int walk_route(input logic [NODE_W-1:0] src,
                                    input logic [NODE_W-1:0] dst);
    int                            n;
    int                            cur;
    int                            prev;
    int                            best_idx;
    bit                            found;
    logic signed [WEIGHT_IN_W-1:0] best;
    logic signed [WEIGHT_IN_W-1:0] w;
    logic [COST_W:0]               sum;
    n             = active_nodes();
    route_len     = 1;
    route_path[0] = src;
    route_cost    = '0;
    if (src >= n || dst >= n) begin
      route_status = ST_DEAD_END;
      return -1;
    end
    if (src == dst) begin
      route_status = ST_SAME_NODE;
      return -1;
    end
    cur          = src;
    prev         = -1;
    route_status = ST_STEP_LIMIT;
    while (cur != dst) begin
      found    = 1'b0;
      best     = '0;
      best_idx = 0;
      // Scan the whole row: cheapest positive edge, lowest index on ties,
      // skip only the node just left.
      for (int j = 0; j < n; j++) begin
        if (!loaded[cur][j]) return cur;
        w = weight_mat[cur][j];
        if (w > 0 && j != prev && (!found || w < best)) begin
          best     = w;
          best_idx = j;
          found    = 1'b1;
        end
      end
      if (!found) begin
        route_status = ST_DEAD_END;
        break;
      end
      sum        = route_cost + best[WEIGHT_IN_W-2:0];
      route_cost = (sum > COST_MAX) ? COST_MAX : sum[COST_W-1:0];
      prev       = cur;
      cur        = best_idx;
      route_path[route_len] = NODE_W'(best_idx);
      route_len++;
      // Stop after n-1 moves.
      if (route_len >= n) break;
    end
    if (cur == dst) route_status = ST_REACHED;
    return -1;
  endfunction

  function automatic logic signed [WEIGHT_IN_W-1:0] rand_weight();
    case ($urandom_range(0, 9))
      0, 1, 2: return WEIGHT_IN_W'($urandom_range(1, 12));  // small costs, ties likely
      3:       return WEIGHT_IN_W'($urandom_range(1, 32767));
      4:       return '0;
      5:       return -WEIGHT_IN_W'($urandom_range(1, 40));
      default: return WEIGHT_IN_W'($urandom);
    endcase
  endfunction

  // Present one request, hold it until the handshake, then update the mirror.
  // Leave valid high afterwards; whoever waits next drops it.
  task automatic send_item(input logic                          kind,
                           input logic [NODE_W-1:0]             r,
                           input logic [NODE_W-1:0]             c,
                           input logic signed [WEIGHT_IN_W-1:0] w,
                           input logic [NODE_W-1:0]             src,
                           input logic [NODE_W-1:0]             dst);
    route_result_t res;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= kind;
    req_if.row        <= r;
    req_if.col        <= c;
    req_if.weight     <= w;
    req_if.start_node <= src;
    req_if.end_node   <= dst;
    do @(posedge clk_i); while (!req_if.ready);
    if (kind == REQ_LOAD) begin
      weight_mat[r][c] = w;
      loaded[r][c]     = 1'b1;
      loads_sent++;
    end else begin
      void'(walk_route(src, dst));
      for (int k = 0; k < route_len; k++) begin
        res.node       = route_path[k];
        res.total_cost = route_cost;
        res.status     = route_status;
        res.is_last    = (k == route_len - 1);
        expected_results.push_back(res);
      end
      routes_sent++;
    end
  endtask

  task automatic send_load(input logic [NODE_W-1:0] r, input logic [NODE_W-1:0] c,
                           input logic signed [WEIGHT_IN_W-1:0] w);
    send_item(REQ_LOAD, r, c, w, NODE_W'($urandom), NODE_W'($urandom));
  endtask

  // Load every row the walk would scan before the query goes out, so the
  // unit never reads a weight that was not written.
  task automatic send_route(input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst);
    int gap_row;
    gap_row = walk_route(src, dst);
    while (gap_row >= 0) begin
      for (int j = 0; j < active_nodes(); j++)
        if (!loaded[gap_row][j]) send_load(NODE_W'(gap_row), NODE_W'(j), rand_weight());
      gap_row = walk_route(src, dst);
    end
    send_item(REQ_ROUTE, NODE_W'($urandom), NODE_W'($urandom), WEIGHT_IN_W'($urandom),
              src, dst);
  endtask

  // Drop valid, wait for every outstanding result, then give a trailing load
  // time to land.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_node_count(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_nodes   = value;
  endtask

  // Hand-built 4-node graph: tied edges, a self edge that wins, weight
  // extremes, a node whose only edge leads back, and a dead start.
  task automatic test_directed_walks();
    logic signed [WEIGHT_IN_W-1:0] grid [4][4] = '{
      '{16'sd0, 16'sd3,  16'sd3, -16'sd32768},
      '{16'sd2, 16'sd1,  16'sd4,  16'sd32767},
      '{16'sd4, 16'sd9,  16'sd0,  16'sd1},
      '{16'sd0, -16'sd1, 16'sd5, -16'sd32768}
    };
    set_node_count(7'd4);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        send_load(NODE_W'(r), NODE_W'(c), grid[r][c]);
    send_route(6'd1, 6'd0);    // self edge taken, then reach
    send_route(6'd0, 6'd3);    // step limit
    send_route(6'd1, 6'd2);    // end reached on the last allowed move
    send_route(6'd2, 6'd1);    // dead end after one move
    send_route(6'd3, 6'd0);    // reach through node 2
    send_route(6'd2, 6'd2);    // start equals end
    send_route(6'd5, 6'd0);    // start past node count
    send_route(6'd0, 6'd63);   // end past node count
    send_route(6'd63, 6'd63);  // both past node count, equal
    send_load(6'd3, 6'd2, 16'sd0);
    send_route(6'd3, 6'd1);    // no edge at the start node
  endtask

  task automatic test_node_count_extremes();
    set_node_count(7'd0);      // acts as one node
    send_route(6'd0, 6'd0);
    send_route(6'd0, 6'd1);
    send_route(6'd1, 6'd1);
    set_node_count(7'd1);
    send_route(6'd0, 6'd0);
    send_route(6'd1, 6'd0);
    set_node_count(7'd127);    // acts as the full matrix
    send_route(6'd63, 6'd63);  // top node still in range
    send_route(6'd0, 6'd0);
  endtask

  // Stall the result side for a long stretch while queries keep coming, so
  // the unit holds a result and blocks its request side.
  task automatic test_backpressure();
    set_node_count(7'd4);
    idle_en         = 1'b0;
    rsp_hold_cycles = 400;
    for (int i = 0; i < 6; i++)
      send_route(NODE_W'($urandom_range(0, 3)), NODE_W'($urandom_range(0, 3)));
    idle_en = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int                phase_nodes [8] = '{5, 3, 6, 2, 4, 6, 3, 5};
    int                n;
    int                items;
    int                pick;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    for (int p = 0; p < 8; p++) begin
      set_node_count(CFG_W'(phase_nodes[p]));
      // Keep idling random per phase; run the last phase at full rate.
      idle_en = (p != 7) && ($urandom_range(0, 3) != 0);
      n       = active_nodes();
      items   = 11;
      for (int i = 0; i < items; i++) begin
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
          if (pick == 0) begin
            a = NODE_W'($urandom);
            b = NODE_W'($urandom);
          end else begin
            a = NODE_W'($urandom_range(0, n - 1));
            b = NODE_W'($urandom_range(0, n - 1));
          end
          send_load(a, b, rand_weight());
        end else begin
          if (pick == 8) begin
            a = NODE_W'($urandom);
            b = NODE_W'($urandom);
          end else if (pick == 9) begin
            a = NODE_W'($urandom_range(0, n - 1));
            b = a;
          end else begin
            a = NODE_W'($urandom_range(0, n - 1));
            b = NODE_W'($urandom_range(0, n - 1));
          end
          send_route(a, b);
        end
        // Pause the request side mid-phase until everything is back.
        if (i == items / 2) wait_drained();
      end
    end
  endtask

  // Result side: random stall bursts, plus the long hold that a test asks for.
  initial begin : rsp_ready_drive
    int stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_hold_cycles > 0) begin
        rsp_hold_cycles--;
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 12);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result with the oldest expectation.
  initial begin : route_result_check
    route_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: node %0d", rsp_if.node);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (want.is_last) status_seen[want.status]++;
          if (rsp_if.node !== want.node) begin
            $error("node: expected %0d, got %0d", want.node, rsp_if.node);
            error_count++;
          end
          if (rsp_if.total_cost !== want.total_cost) begin
            $error("total_cost: expected %0d, got %0d", want.total_cost, rsp_if.total_cost);
            error_count++;
          end
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_if.status);
            error_count++;
          end
          if (rsp_if.is_last !== want.is_last) begin
            $error("is_last: expected %0d, got %0d", want.is_last, rsp_if.is_last);
            error_count++;
          end
        end
      end
    end
  end

  // End the run when nothing moves on any port for too long.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we_i)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("greedy_nearest_neighbour_route_unit verification failed");
      $finish;
    end
  end

  initial begin : test_sequence
    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_LOAD;
    req_if.row        <= '0;
    req_if.col        <= '0;
    req_if.weight     <= '0;
    req_if.start_node <= '0;
    req_if.end_node   <= '0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_walks();
    test_node_count_extremes();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (64) @(posedge clk_i);
    $display("Sent %0d weight loads and %0d route queries across node counts 0 to 127.",
             loads_sent, routes_sent);
    $display("Checked %0d results: %0d reached, %0d step limit, %0d dead end, %0d same node.",
             results_seen, status_seen[ST_REACHED], status_seen[ST_STEP_LIMIT],
             status_seen[ST_DEAD_END], status_seen[ST_SAME_NODE]);
    if (error_count == 0) begin
      $display("greedy_nearest_neighbour_route_unit verification clean");
    end else begin
      $display("greedy_nearest_neighbour_route_unit verification failed");
    end
    $finish;
  end

endmodule
